// File: sv/abr_pkg.sv
// Package with the payload types, register codes and result kinds of the box step resolver.
package abr_pkg;

  localparam int unsigned POS_W = 24;
  localparam int unsigned SIZE_W = 20;

  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] REQ_LOAD_BODY = 2'd1;
  localparam logic [1:0] REQ_STEP = 2'd2;

  localparam logic [1:0] KIND_HIT_X = 2'd0;
  localparam logic [1:0] KIND_HIT_Y = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  localparam logic [2:0] CFG_GRAVITY = 3'd0;
  localparam logic [2:0] CFG_DAMPING = 3'd1;
  localparam logic [2:0] CFG_FRAME_TIME = 3'd2;
  localparam logic [2:0] CFG_FALL_LIMIT = 3'd3;
  localparam logic [2:0] CFG_STATIC = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] entry_index;
    logic signed [23:0] pos_x_in;
    logic signed [23:0] pos_y_in;
    logic [19:0] width_in;
    logic [19:0] height_in;
    logic signed [23:0] vel_x_in;
    logic signed [23:0] vel_y_in;
    logic visible_in;
    logic trigger_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] hit_index;
    logic signed [23:0] pos_x_out;
    logic signed [23:0] pos_y_out;
    logic signed [23:0] vel_x_out;
    logic signed [23:0] vel_y_out;
    logic grounded_out;
    logic last_result;
  } out_item_t;

  // Saturate a wider signed value to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) return 24'sh7FFFFF;
    else if (v < lo) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

// File: sv/abr_box_mem.sv
// Box table memory: one write port, one registered read port.
module abr_box_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [87:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [87:0]   rdata
);
  logic [87:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/aabb_body_step_resolver_top.sv
// Top level of the box step resolver: body state, sequencer and box table.
// A load leaves busy low, so the next beat may follow at once. A step raises busy; when the
// body is static it goes straight to S_FIN. Otherwise it runs the velocity and move
// arithmetic states S_MULA to S_MOVE, then reads the table once per entry for the x pass and
// again for the y pass (read, test, push-out per entry), runs the y move states S_YMV and
// S_YMV2 between the passes, and ends in S_FIN, which forms the final state. Results appear
// as a one-cycle strobe on out_valid, hits in entry order, then the final state with
// last_result set in the cycle in which busy has fallen; the receiver cannot stall them.
module aabb_body_step_resolver_top #(
  parameter int unsigned MAX_OBJECTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  abr_pkg::in_item_t   in_item,
  output logic                out_valid,
  output abr_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  localparam int unsigned AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_OBJECTS + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MULA = 12'b000000000010,
    S_MULB = 12'b000000000100,
    S_MULC = 12'b000000001000,
    S_MULD = 12'b000000010000,
    S_MOVE = 12'b000000100000,
    S_RD   = 12'b000001000000,
    S_TEST = 12'b000010000000,
    S_PUSH = 12'b000100000000,
    S_YMV  = 12'b001000000000,
    S_YMV2 = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [23:0] gravity_r;
  logic [15:0] damping_r, dt_r;
  logic signed [23:0] fall_limit_r;
  logic static_r;

  logic signed [23:0] bl_r, bt_r, vx_r, vy_r;
  logic [19:0] bw_r, bh_r;
  logic grounded_r;
  logic [MAX_OBJECTS-1:0] vis_r, trig_r;

  logic [CW-1:0] idx_r;
  logic ypass_r;
  logic signed [48:0] prod_r;
  logic signed [25:0] factor_r;

  logic mem_we;
  logic [87:0] mem_rd;
  logic [AW-1:0] raddr;
  logic [AW-1:0] cur_idx;

  logic signed [23:0] box_l, box_t;
  logic [19:0] box_w, box_h;
  logic signed [25:0] ov_a, ov_b;
  logic hit_c, hit_r;
  logic signed [25:0] o1_r, o2_r;

  logic out_valid_r;
  abr_pkg::out_item_t out_r;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;
  assign cur_idx = idx_r[AW-1:0];
  assign raddr = cur_idx;
  assign mem_we = start && !busy && in_item.req_type == abr_pkg::REQ_LOAD_ENTRY
                  && {1'b0, in_item.entry_index} < 5'(MAX_OBJECTS);

  abr_box_mem #(.DEPTH(MAX_OBJECTS), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(in_item.entry_index)),
    .wdata({in_item.pos_x_in, in_item.pos_y_in, in_item.width_in, in_item.height_in}),
    .raddr(raddr),
    .rdata(mem_rd)
  );

  assign box_l = mem_rd[87:64];
  assign box_t = mem_rd[63:40];
  assign box_w = mem_rd[39:20];
  assign box_h = mem_rd[19:0];

  always_comb begin
    hit_c = !((26'(bl_r) + 26'($signed({1'b0, bw_r})) <= 26'(box_l)) ||
              (26'(bl_r) >= 26'(box_l) + 26'($signed({1'b0, box_w}))) ||
              (26'(bt_r) + 26'($signed({1'b0, bh_r})) <= 26'(box_t)) ||
              (26'(bt_r) >= 26'(box_t) + 26'($signed({1'b0, box_h}))));
    if (!ypass_r) begin
      ov_a = 26'(box_l) + 26'($signed({1'b0, box_w})) - 26'(bl_r);
      ov_b = 26'(bl_r) + 26'($signed({1'b0, bw_r})) - 26'(box_l);
    end else begin
      ov_a = 26'(box_t) + 26'($signed({1'b0, box_h})) - 26'(bt_r);
      ov_b = 26'(bt_r) + 26'($signed({1'b0, bh_r})) - 26'(box_t);
    end
  end

  // Rounded arithmetic right shift of the product, ties toward plus infinity.
  function automatic logic signed [48:0] rsh(input logic signed [48:0] v, input int n);
    logic signed [48:0] t;
    t = v + (49'sd1 <<< (n - 1));
    return t >>> n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start && in_item.req_type == abr_pkg::REQ_STEP) begin
        state_nxt = static_r ? S_FIN : S_MULA;
      end
      S_MULA: state_nxt = S_MULB;
      S_MULB: state_nxt = S_MULC;
      S_MULC: state_nxt = S_MULD;
      S_MULD: state_nxt = S_MOVE;
      S_MOVE: state_nxt = S_RD;
      S_RD:   state_nxt = S_TEST;
      S_TEST: state_nxt = S_PUSH;
      S_PUSH: begin
        if (idx_r == CW'(MAX_OBJECTS - 1)) begin
          state_nxt = ypass_r ? S_FIN : S_YMV;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_YMV:  state_nxt = S_YMV2;
      S_YMV2: state_nxt = S_RD;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gravity_r <= '0;
      damping_r <= '0;
      dt_r <= '0;
      fall_limit_r <= 24'sh7FFFFF;
      static_r <= 1'b0;
      bl_r <= '0; bt_r <= '0; vx_r <= '0; vy_r <= '0;
      bw_r <= '0; bh_r <= '0;
      grounded_r <= 1'b0;
      vis_r <= '0; trig_r <= '0;
      idx_r <= '0;
      ypass_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          abr_pkg::CFG_GRAVITY:    gravity_r <= cfg_data;
          abr_pkg::CFG_DAMPING:    damping_r <= cfg_data[15:0];
          abr_pkg::CFG_FRAME_TIME: dt_r <= cfg_data[15:0];
          abr_pkg::CFG_FALL_LIMIT: fall_limit_r <= cfg_data;
          abr_pkg::CFG_STATIC:     static_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (mem_we) begin
            vis_r[AW'(in_item.entry_index)] <= in_item.visible_in;
            trig_r[AW'(in_item.entry_index)] <= in_item.trigger_in;
          end
          if (start && in_item.req_type == abr_pkg::REQ_LOAD_BODY) begin
            bl_r <= in_item.pos_x_in; bt_r <= in_item.pos_y_in;
            bw_r <= in_item.width_in; bh_r <= in_item.height_in;
            vx_r <= in_item.vel_x_in; vy_r <= in_item.vel_y_in;
          end
          // Damping product rate*dt fits in 32 bits.
          prod_r <= 49'($signed({1'b0, damping_r}) * $signed({1'b0, dt_r}));
          idx_r <= '0;
          ypass_r <= 1'b0;
        end
        S_MULA: begin
          if (prod_r >= 49'sd16777216) factor_r <= '0;
          else factor_r <= 26'(49'sd16777216 - prod_r);
          prod_r <= 49'(gravity_r * $signed({1'b0, dt_r}));
        end
        S_MULB: begin
          vy_r <= (abr_pkg::sat24(28'(26'(vy_r) + 26'(rsh(prod_r, 16)))) > fall_limit_r)
                  ? fall_limit_r : abr_pkg::sat24(28'(26'(vy_r) + 26'(rsh(prod_r, 16))));
          prod_r <= 49'(vx_r * factor_r);
        end
        S_MULC: begin
          vx_r <= abr_pkg::sat24(28'(rsh(prod_r, 24)));
          prod_r <= 49'(abr_pkg::sat24(28'(rsh(prod_r, 24))) * $signed({1'b0, dt_r}));
        end
        S_MULD: begin
          bl_r <= abr_pkg::sat24(28'(26'(bl_r) + 26'(rsh(prod_r, 16))));
        end
        S_MOVE: ;
        S_RD: ;
        S_TEST: begin
          hit_r <= hit_c && vis_r[cur_idx];
          o1_r <= ov_a;
          o2_r <= ov_b;
        end
        S_PUSH: begin
          if (hit_r) begin
            out_valid_r <= 1'b1;
            out_r.result_kind <= ypass_r ? abr_pkg::KIND_HIT_Y : abr_pkg::KIND_HIT_X;
            out_r.hit_index <= 4'(cur_idx);
            out_r.last_result <= 1'b0;
            out_r.pos_x_out <= bl_r; out_r.pos_y_out <= bt_r;
            out_r.vel_x_out <= vx_r; out_r.vel_y_out <= vy_r;
            out_r.grounded_out <= grounded_r;
            if (!trig_r[cur_idx]) begin
              if (!ypass_r) begin
                vx_r <= '0; out_r.vel_x_out <= '0;
                if (o1_r < o2_r) begin
                  bl_r <= abr_pkg::sat24(28'(bl_r) + 28'(o1_r));
                  out_r.pos_x_out <= abr_pkg::sat24(28'(bl_r) + 28'(o1_r));
                end else begin
                  bl_r <= abr_pkg::sat24(28'(bl_r) - 28'(o2_r));
                  out_r.pos_x_out <= abr_pkg::sat24(28'(bl_r) - 28'(o2_r));
                end
              end else begin
                vy_r <= '0; out_r.vel_y_out <= '0;
                if (o2_r < o1_r) begin
                  bt_r <= abr_pkg::sat24(28'(bt_r) - 28'(o2_r));
                  out_r.pos_y_out <= abr_pkg::sat24(28'(bt_r) - 28'(o2_r));
                  grounded_r <= 1'b1; out_r.grounded_out <= 1'b1;
                end else begin
                  bt_r <= abr_pkg::sat24(28'(bt_r) + 28'(o1_r));
                  out_r.pos_y_out <= abr_pkg::sat24(28'(bt_r) + 28'(o1_r));
                end
              end
            end
          end
          idx_r <= (idx_r == CW'(MAX_OBJECTS - 1)) ? '0 : idx_r + 1'b1;
        end
        S_YMV: begin
          ypass_r <= 1'b1;
          grounded_r <= 1'b0;
          prod_r <= 49'(vy_r * $signed({1'b0, dt_r}));
        end
        S_YMV2: begin
          bt_r <= abr_pkg::sat24(28'(26'(bt_r) + 26'(rsh(prod_r, 16))));
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_r.result_kind <= abr_pkg::KIND_FINAL;
          out_r.hit_index <= '0;
          out_r.last_result <= 1'b1;
          out_r.pos_x_out <= bl_r; out_r.pos_y_out <= bt_r;
          out_r.vel_x_out <= vx_r; out_r.vel_y_out <= vy_r;
          out_r.grounded_out <= grounded_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: sv/abr_checker.sv
// Port-level checker for the box step resolver, bound to the top level.
module abr_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input abr_pkg::out_item_t out_item
);
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |-> out_item.result_kind == abr_pkg::KIND_FINAL)
    else $error("last result is not a final state beat");
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |-> !busy)
    else $error("busy after the final beat");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |-> busy)
    else $error("hit beat while idle");
  a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind != abr_pkg::KIND_FINAL |-> !out_item.last_result)
    else $error("hit beat marked last");
endmodule

bind aabb_body_step_resolver_top abr_checker u_abr_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

// File: tb/sv/tb_aabb_body_step_resolver_top.sv
// Self-checking testbench for the box step resolver: random loads and steps against a predictor.
`timescale 1ns / 1ps

module tb_aabb_body_step_resolver_top;

  localparam int NBOX = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam longint S24_MAX = 64'sd8388607;
  localparam longint S24_MIN = -64'sd8388608;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN, OP_GAP} op_kind_t;

  typedef struct {
    op_kind_t   kind;
    abr_pkg::in_item_t item;
    logic [2:0] idx;
    logic [23:0] data;
    int         pct;
  } stim_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  abr_pkg::in_item_t in_item = '0;
  logic out_valid;
  abr_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  aabb_body_step_resolver_top #(.MAX_OBJECTS(NBOX)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  stim_op_t stim_q[$];
  abr_pkg::out_item_t pending_results[$];
  int in_sent = 0, in_taken = 0, cfg_sent = 0, cfg_taken = 0;
  int idle_pct = 0;
  int quiet = 0;
  int stall = 0;
  int mismatches = 0;
  bit failed = 0;

  // Predicted block state.
  longint box_x[NBOX], box_y[NBOX], box_w[NBOX], box_h[NBOX];
  bit box_vis[NBOX], box_trig[NBOX];
  longint body_x = 0, body_y = 0, body_vx = 0, body_vy = 0, body_w = 0, body_h = 0;
  bit on_ground = 0;
  longint grav = 0, damp = 0, ftime = 0, fall_lim = S24_MAX;
  bit frozen = 0;

  initial begin
    for (int i = 0; i < NBOX; i++) begin
      box_vis[i] = 0;
      box_trig[i] = 0;
    end
  end

  function automatic longint clamp24(longint v);
    if (v > S24_MAX) return S24_MAX;
    if (v < S24_MIN) return S24_MIN;
    return v;
  endfunction

  // Round to nearest, ties toward plus infinity; >>> on longint floors.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic bit body_hits(int i);
    return !(body_x + body_w <= box_x[i] || body_x >= box_x[i] + box_w[i] ||
             body_y + body_h <= box_y[i] || body_y >= box_y[i] + box_h[i]);
  endfunction

  function automatic void post_result(logic [1:0] kind, int idx, bit last);
    abr_pkg::out_item_t r;
    r.result_kind = kind;
    r.hit_index = idx[3:0];
    r.pos_x_out = body_x[23:0];
    r.pos_y_out = body_y[23:0];
    r.vel_x_out = body_vx[23:0];
    r.vel_y_out = body_vy[23:0];
    r.grounded_out = on_ground;
    r.last_result = last;
    pending_results.push_back(r);
  endfunction

  function automatic void resolve_request(abr_pkg::in_item_t it);
    longint factor, ov_a, ov_b;
    int k;
    case (it.req_type)
      abr_pkg::REQ_LOAD_ENTRY: begin
        k = it.entry_index;
        box_x[k] = longint'($signed(it.pos_x_in));
        box_y[k] = longint'($signed(it.pos_y_in));
        box_w[k] = longint'(it.width_in);
        box_h[k] = longint'(it.height_in);
        box_vis[k] = it.visible_in;
        box_trig[k] = it.trigger_in;
      end
      abr_pkg::REQ_LOAD_BODY: begin
        body_x = longint'($signed(it.pos_x_in));
        body_y = longint'($signed(it.pos_y_in));
        body_w = longint'(it.width_in);
        body_h = longint'(it.height_in);
        body_vx = longint'($signed(it.vel_x_in));
        body_vy = longint'($signed(it.vel_y_in));
      end
      abr_pkg::REQ_STEP: begin
        if (!frozen) begin
          factor = (64'sd1 <<< 24) - damp * ftime;
          if (factor < 0) factor = 0;
          body_vx = clamp24(round_shift(body_vx * factor, 24));
          body_vy = clamp24(body_vy + round_shift(grav * ftime, 16));
          if (body_vy > fall_lim) body_vy = fall_lim;
          body_x = clamp24(body_x + round_shift(body_vx * ftime, 16));
          for (int i = 0; i < NBOX; i++) begin
            if (box_vis[i] && body_hits(i)) begin
              if (!box_trig[i]) begin
                ov_a = (box_x[i] + box_w[i]) - body_x;
                ov_b = (body_x + body_w) - box_x[i];
                body_x = (ov_a < ov_b) ? clamp24(body_x + ov_a) : clamp24(body_x - ov_b);
                body_vx = 0;
              end
              post_result(abr_pkg::KIND_HIT_X, i, 0);
            end
          end
          on_ground = 0;
          body_y = clamp24(body_y + round_shift(body_vy * ftime, 16));
          for (int i = 0; i < NBOX; i++) begin
            if (box_vis[i] && body_hits(i)) begin
              if (!box_trig[i]) begin
                ov_a = (box_y[i] + box_h[i]) - body_y;
                ov_b = (body_y + body_h) - box_y[i];
                if (ov_b < ov_a) begin
                  body_y = clamp24(body_y - ov_b);
                  on_ground = 1;
                end else begin
                  body_y = clamp24(body_y + ov_a);
                end
                body_vy = 0;
              end
              post_result(abr_pkg::KIND_HIT_Y, i, 0);
            end
          end
        end
        post_result(abr_pkg::KIND_FINAL, 0, 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [23:0] d);
    case (idx)
      abr_pkg::CFG_GRAVITY:    grav = longint'($signed(d));
      abr_pkg::CFG_DAMPING:    damp = longint'(d[15:0]);
      abr_pkg::CFG_FRAME_TIME: ftime = longint'(d[15:0]);
      abr_pkg::CFG_FALL_LIMIT: fall_lim = longint'($signed(d));
      abr_pkg::CFG_STATIC:     frozen = d[0];
      default: ;
    endcase
  endfunction

  // Acceptance, prediction and result checking, all on the rising edge.
  always @(posedge clk) begin
    abr_pkg::out_item_t want;
    bit moved;
    if (rst_n) begin
      moved = 0;
      quiet <= (busy || out_valid) ? 0 : quiet + 1;
      if (start && !busy) begin
        resolve_request(in_item);
        in_taken <= in_taken + 1;
        moved = 1;
      end
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        cfg_taken <= cfg_taken + 1;
        moved = 1;
      end
      if (out_valid) begin
        moved = 1;
        if (pending_results.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: %p", out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.result_kind !== want.result_kind ||
              out_item.hit_index !== want.hit_index ||
              out_item.pos_x_out !== want.pos_x_out ||
              out_item.pos_y_out !== want.pos_y_out ||
              out_item.vel_x_out !== want.vel_x_out ||
              out_item.vel_y_out !== want.vel_y_out ||
              out_item.grounded_out !== want.grounded_out ||
              out_item.last_result !== want.last_result) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
      stall <= moved ? 0 : stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("tb_aabb_body_step_resolver_top NOT OK");
        $finish;
      end
    end
  end

  // Driver: one beat at a time from the stimulus queue, changes on the falling edge.
  always @(negedge clk) begin
    logic n_start, n_cfg;
    bit settled;
    stim_op_t op;
    if (rst_n) begin
      n_start = start;
      n_cfg = cfg_valid;
      settled = pending_results.size() == 0 && !busy && quiet >= SETTLE_CYCLES;
      if (start && in_taken == in_sent) n_start = 0;
      if (cfg_valid && cfg_taken == cfg_sent) n_cfg = 0;
      if (!n_start && !n_cfg && stim_q.size() > 0) begin
        op = stim_q[0];
        case (op.kind)
          OP_GAP: begin
            idle_pct = op.pct;
            void'(stim_q.pop_front());
          end
          OP_DRAIN: if (settled) void'(stim_q.pop_front());
          OP_CFG: if (settled) begin
            n_cfg = 1;
            cfg_index <= op.idx;
            cfg_data <= op.data;
            cfg_sent++;
            void'(stim_q.pop_front());
          end
          OP_ITEM: if ($urandom_range(99) >= idle_pct) begin
            n_start = 1;
            in_item <= op.item;
            in_sent++;
            void'(stim_q.pop_front());
          end
          default: ;
        endcase
      end
      start <= n_start;
      cfg_valid <= n_cfg;
    end
  end

  function automatic abr_pkg::in_item_t make_req(logic [1:0] req, int idx, int x, int y,
                                                 int w, int h, int vx, int vy, bit vis,
                                                 bit trig);
    abr_pkg::in_item_t it;
    it.req_type = req;
    it.entry_index = idx[3:0];
    it.pos_x_in = x[23:0];
    it.pos_y_in = y[23:0];
    it.width_in = w[19:0];
    it.height_in = h[19:0];
    it.vel_x_in = vx[23:0];
    it.vel_y_in = vy[23:0];
    it.visible_in = vis;
    it.trigger_in = trig;
    return it;
  endfunction

  function automatic void add_item(abr_pkg::in_item_t it);
    stim_op_t op;
    op.kind = OP_ITEM;
    op.item = it;
    stim_q.push_back(op);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [23:0] d);
    stim_op_t op;
    op.kind = OP_CFG;
    op.idx = idx;
    op.data = d;
    stim_q.push_back(op);
  endfunction

  function automatic void add_ctl(op_kind_t kind, int pct);
    stim_op_t op;
    op.kind = kind;
    op.pct = pct;
    stim_q.push_back(op);
  endfunction

  function automatic int near_coord();
    return $urandom_range(24576) - 12288;
  endfunction

  // Mostly a small scene around the body so that steps collide; a few raw beats.
  function automatic abr_pkg::in_item_t random_req();
    abr_pkg::in_item_t it;
    logic [191:0] raw;
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(abr_pkg::in_item_t)-1:0];
    end else if (r < 32) begin
      it = make_req(abr_pkg::REQ_LOAD_ENTRY, $urandom_range(15), near_coord(), near_coord(),
                    $urandom_range(8192, 0), $urandom_range(8192, 0), 0, 0,
                    $urandom_range(99) < 85, $urandom_range(99) < 25);
    end else if (r < 42) begin
      it = make_req(abr_pkg::REQ_LOAD_BODY, $urandom_range(15), near_coord(), near_coord(),
                    $urandom_range(4096, 0), $urandom_range(4096, 0),
                    $urandom_range(65536) - 32768, $urandom_range(65536) - 32768, 0, 0);
    end else begin
      it = make_req(abr_pkg::REQ_STEP, $urandom_range(15), 0, 0, 0, 0, 0, 0, 0, 0);
    end
    return it;
  endfunction

  initial begin
    abr_pkg::in_item_t step_req;
    step_req = make_req(abr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // Phase one: moderate settings, directed scene, then random.
    add_ctl(OP_GAP, 22);
    add_cfg(abr_pkg::CFG_GRAVITY, 24'h000800);
    add_cfg(abr_pkg::CFG_DAMPING, 24'h000100);
    add_cfg(abr_pkg::CFG_FRAME_TIME, 24'h001000);
    add_cfg(abr_pkg::CFG_FALL_LIMIT, 24'h004000);
    add_cfg(abr_pkg::CFG_STATIC, 24'h000000);
    add_item(make_req(abr_pkg::REQ_LOAD_ENTRY, 0, -16384, 2048, 32768, 1024, 0, 0, 1, 0));
    add_item(make_req(abr_pkg::REQ_LOAD_ENTRY, 1, 1536, -8192, 1024, 16384, 0, 0, 1, 0));
    add_item(make_req(abr_pkg::REQ_LOAD_ENTRY, 2, -512, -512, 2048, 2048, 0, 0, 1, 1));
    add_item(make_req(abr_pkg::REQ_LOAD_ENTRY, 15, 8388607, -8388608, 1048575, 1048575,
                      0, 0, 0, 1));
    add_item(make_req(2'd3, 7, -1, -1, 1048575, 1048575, -1, -1, 1, 1));
    add_item(make_req(abr_pkg::REQ_LOAD_BODY, 0, 0, 0, 1024, 2048, 32768, 8192, 0, 0));
    repeat (4) add_item(step_req);
    add_item(make_req(abr_pkg::REQ_LOAD_BODY, 0, 8388607, 8388607, 1048575, 1048575,
                      -8388608, 8388607, 0, 0));
    add_item(step_req);
    add_item(make_req(abr_pkg::REQ_LOAD_BODY, 0, -8388608, -8388608, 0, 0, 8388607,
                      -8388608, 0, 0));
    add_item(step_req);
    add_cfg(abr_pkg::CFG_STATIC, 24'h000001);
    add_item(make_req(abr_pkg::REQ_LOAD_BODY, 0, -256, 0, 1024, 1024, 4096, 4096, 0, 0));
    add_item(step_req);
    add_cfg(abr_pkg::CFG_STATIC, 24'h000000);
    add_item(step_req);
    for (int i = 0; i < 70; i++) begin
      add_item(random_req());
      if (i == 35) add_ctl(OP_DRAIN, 0);
    end

    // Phase two: extreme settings, sender mostly idle.
    add_ctl(OP_GAP, 72);
    add_cfg(abr_pkg::CFG_GRAVITY, 24'h7FFFFF);
    add_cfg(abr_pkg::CFG_DAMPING, 24'h00FFFF);
    add_cfg(abr_pkg::CFG_FRAME_TIME, 24'h00FFFF);
    add_cfg(abr_pkg::CFG_FALL_LIMIT, 24'h800000);
    for (int i = 0; i < 35; i++) add_item(random_req());
    add_cfg(abr_pkg::CFG_GRAVITY, 24'h800000);
    add_cfg(abr_pkg::CFG_DAMPING, 24'h000000);
    add_cfg(abr_pkg::CFG_FALL_LIMIT, 24'h7FFFFF);
    for (int i = 0; i < 35; i++) add_item(random_req());

    // Phase three: random settings, back-to-back requests.
    add_ctl(OP_GAP, 0);
    add_cfg(abr_pkg::CFG_FRAME_TIME, 24'h000000);
    for (int i = 0; i < 10; i++) add_item(random_req());
    add_cfg(abr_pkg::CFG_GRAVITY, 24'($urandom_range(131072) - 65536));
    add_cfg(abr_pkg::CFG_DAMPING, 24'($urandom_range(1024)));
    add_cfg(abr_pkg::CFG_FRAME_TIME, 24'($urandom_range(8192, 256)));
    add_cfg(abr_pkg::CFG_FALL_LIMIT, 24'($urandom_range(65536, 1024)));
    for (int i = 0; i < 60; i++) add_item(random_req());

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(stim_q.size() == 0 && !start && !cfg_valid && pending_results.size() == 0
             && !busy))
      @(posedge clk);
    repeat (80) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("tb_aabb_body_step_resolver_top OK");
    else
      $display("tb_aabb_body_step_resolver_top NOT OK");
    $finish;
  end

endmodule
